// ===== hdl/ffea_pkg.sv =====
// Shared types and constants for the first-fit extent allocator.
`timescale 1ns / 1ps

package ffea_pkg;

  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QOCC_W      = $clog2(QUEUE_DEPTH + 1);

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_NOFIT = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Request classes handed from front to back
  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_ZERO  = 2'd2,
    CMD_NOFIT = 2'd3
  } cmd_kind_t;

  // Classified request: amount is the rounded size for an allocate,
  // the extent length for a load
  typedef struct packed {
    cmd_kind_t           kind;
    logic [DATA_W-1:0]   base;
    logic [DATA_W-1:0]   amount;
  } cmd_t;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] len;
  } slot_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN_RD,
    BK_SCAN_CMP,
    BK_MOV_RD,
    BK_MOV_WR,
    BK_FINISH
  } bk_state_t;

endpackage

// ===== hdl/ffea_req_if.sv =====
// Request channel: valid/ready handshake with the request fields.
`timescale 1ns / 1ps

interface ffea_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] req_bytes;
  logic [31:0] extent_start;
  logic [31:0] extent_size;

  modport source (output valid, output req_type, output req_bytes,
                  output extent_start, output extent_size, input ready);
  modport sink   (input valid, input req_type, input req_bytes,
                  input extent_start, input extent_size, output ready);
endinterface

// ===== hdl/ffea_rsp_if.sv =====
// Result channel: valid/ready handshake with the result fields.
`timescale 1ns / 1ps

interface ffea_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] alloc_address;
  logic [31:0] free_remaining;

  modport source (output valid, output status, output alloc_address,
                  output free_remaining, input ready);
  modport sink   (input valid, input status, input alloc_address,
                  input free_remaining, output ready);
endinterface

// ===== hdl/ffea_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ffea_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/ffea_front.sv =====
// Front end: takes requests, rounds and classifies them, queues commands.
`timescale 1ns / 1ps

module ffea_front #(
  parameter int GRAIN_BYTES = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  ffea_req_if.sink      in_req,
  output logic          q_valid,
  input  logic          q_ready,
  output ffea_pkg::cmd_t q_cmd
);
  import ffea_pkg::*;

  // GRAIN_BYTES is a power of two; rounding is add-then-mask
  localparam logic [DATA_W:0]   GRAIN_ADD  = (DATA_W+1)'(GRAIN_BYTES - 1);
  localparam logic [DATA_W-1:0] GRAIN_MASK = ~(DATA_W'(GRAIN_BYTES - 1));

  cmd_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QOCC_W-1:0] occ_r, occ_nxt;

  logic              push, pop;
  logic [DATA_W:0]   sum_rnd;
  cmd_t              cls_cmd;

  // Classify the incoming request
  always_comb begin
    sum_rnd        = {1'b0, in_req.req_bytes} + GRAIN_ADD;
    cls_cmd.base   = in_req.extent_start;
    cls_cmd.amount = sum_rnd[DATA_W-1:0] & GRAIN_MASK;
    cls_cmd.kind   = CMD_ALLOC;
    if (in_req.req_type) begin
      cls_cmd.kind   = CMD_LOAD;
      cls_cmd.amount = in_req.extent_size;
    end else if (in_req.req_bytes == '0) begin
      cls_cmd.kind = CMD_ZERO;
    end else if (sum_rnd[DATA_W]) begin
      cls_cmd.kind = CMD_NOFIT;
    end
  end

  // Command queue
  assign in_req.ready = (occ_r != QOCC_W'(QUEUE_DEPTH));
  assign push         = in_req.valid && in_req.ready;
  assign q_valid      = (occ_r != '0);
  assign pop          = q_valid && q_ready;
  assign q_cmd        = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    occ_nxt    = occ_r;
    if (push && !pop) begin
      occ_nxt = occ_r + QOCC_W'(1);
    end else if (pop && !push) begin
      occ_nxt = occ_r - QOCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      occ_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      occ_r    <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls_cmd;
    end
  end

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= QOCC_W'(QUEUE_DEPTH))
    else $error("command queue over capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (occ_r == $past(occ_r) + QOCC_W'(1)))
    else $error("queue occupancy did not grow on push");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (occ_r == $past(occ_r) - QOCC_W'(1)))
    else $error("queue occupancy did not shrink on pop");
`endif

endmodule

// ===== hdl/ffea_back.sv =====
// Back end: runs commands against the extent table and drives results.
`timescale 1ns / 1ps

module ffea_back #(
  parameter int FREE_SLOTS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  ffea_pkg::cmd_t q_cmd,
  ffea_rsp_if.source     out_rsp
);
  import ffea_pkg::*;

  localparam int IDX_W = $clog2(FREE_SLOTS);
  localparam int CNT_W = $clog2(FREE_SLOTS + 1);

  bk_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [DATA_W-1:0]  total_r, total_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [DATA_W-1:0]  need_r, need_nxt;
  logic [DATA_W-1:0]  addr_r, addr_nxt;

  logic               out_valid_r;
  status_t            out_status_r;
  logic [DATA_W-1:0]  out_addr_r;
  logic [DATA_W-1:0]  out_free_r;

  logic               res_load;
  status_t            res_status;
  logic [DATA_W-1:0]  res_addr;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  slot_t              ram_wdata, ram_rdata;

  logic               take;
  logic               table_full;
  logic [CNT_W-1:0]   idx_ext;

  assign take       = q_valid && q_ready;
  assign table_full = (count_r == CNT_W'(FREE_SLOTS));
  assign idx_ext    = CNT_W'(idx_r);

  ffea_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (FREE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (take && q_cmd.kind == CMD_ALLOC && count_r != '0) begin
          state_nxt = BK_SCAN_RD;
        end
      end
      BK_SCAN_RD: state_nxt = BK_SCAN_CMP;
      BK_SCAN_CMP: begin
        if (ram_rdata.len == need_r) begin
          state_nxt = (idx_ext + CNT_W'(1) < count_r) ? BK_MOV_RD : BK_FINISH;
        end else if (ram_rdata.len > need_r) begin
          state_nxt = BK_IDLE;
        end else if (idx_ext + CNT_W'(1) >= count_r) begin
          state_nxt = BK_IDLE;
        end else begin
          state_nxt = BK_SCAN_RD;
        end
      end
      BK_MOV_RD: state_nxt = BK_MOV_WR;
      BK_MOV_WR: begin
        state_nxt = (idx_ext + CNT_W'(2) < count_r) ? BK_MOV_RD : BK_FINISH;
      end
      BK_FINISH: state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and outputs per state
  always_comb begin
    count_nxt  = count_r;
    total_nxt  = total_r;
    idx_nxt    = idx_r;
    need_nxt   = need_r;
    addr_nxt   = addr_r;
    q_ready    = 1'b0;
    res_load   = 1'b0;
    res_status = ST_OK;
    res_addr   = '0;
    ram_we     = 1'b0;
    ram_waddr  = idx_r;
    ram_raddr  = idx_r;
    ram_wdata  = ram_rdata;
    case (state_r)
      BK_IDLE: begin
        // Start a command only when the result register is free
        q_ready = !out_valid_r;
        if (take) begin
          case (q_cmd.kind)
            CMD_LOAD: begin
              res_load = 1'b1;
              if (table_full) begin
                res_status = ST_FULL;
              end else begin
                ram_we         = 1'b1;
                ram_waddr      = count_r[IDX_W-1:0];
                ram_wdata.base = q_cmd.base;
                ram_wdata.len  = q_cmd.amount;
                count_nxt      = count_r + CNT_W'(1);
                total_nxt      = total_r + q_cmd.amount;
              end
            end
            CMD_ZERO: begin
              res_load   = 1'b1;
              res_status = ST_ZERO;
            end
            CMD_NOFIT: begin
              res_load   = 1'b1;
              res_status = ST_NOFIT;
            end
            CMD_ALLOC: begin
              need_nxt = q_cmd.amount;
              idx_nxt  = '0;
              if (count_r == '0) begin
                res_load   = 1'b1;
                res_status = ST_NOFIT;
              end
            end
            default: begin
              res_load   = 1'b1;
              res_status = ST_NOFIT;
            end
          endcase
        end
      end
      BK_SCAN_RD: ram_raddr = idx_r;
      BK_SCAN_CMP: begin
        if (ram_rdata.len == need_r) begin
          // Exact fit: remember base, then close the gap
          addr_nxt = ram_rdata.base;
        end else if (ram_rdata.len > need_r) begin
          // Split: carve the front of the extent
          ram_we         = 1'b1;
          ram_waddr      = idx_r;
          ram_wdata.base = ram_rdata.base + need_r;
          ram_wdata.len  = ram_rdata.len - need_r;
          total_nxt      = total_r - need_r;
          res_load       = 1'b1;
          res_status     = ST_OK;
          res_addr       = ram_rdata.base;
        end else if (idx_ext + CNT_W'(1) >= count_r) begin
          res_load   = 1'b1;
          res_status = ST_NOFIT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      BK_MOV_RD: ram_raddr = idx_r + IDX_W'(1);
      BK_MOV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        idx_nxt   = idx_r + IDX_W'(1);
      end
      BK_FINISH: begin
        count_nxt  = count_r - CNT_W'(1);
        total_nxt  = total_r - need_r;
        res_load   = 1'b1;
        res_status = ST_OK;
        res_addr   = addr_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      total_r <= total_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    need_r <= need_nxt;
    addr_r <= addr_nxt;
    if (res_load) begin
      out_status_r <= res_status;
      out_addr_r   <= res_addr;
      out_free_r   <= total_nxt;
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_status_r;
  assign out_rsp.alloc_address  = out_addr_r;
  assign out_rsp.free_remaining = out_free_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FREE_SLOTS))
    else $error("extent count beyond table size");

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> !out_valid_r)
    else $error("result produced while result register still full");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SCAN_CMP || state_r == BK_MOV_RD) |-> (idx_ext < count_r))
    else $error("table index beyond valid entries");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> (state_r == BK_IDLE))
    else $error("command taken while busy");
`endif

endmodule

// ===== hdl/first_fit_extent_allocator.sv =====
// Top level of the first-fit extent allocator.
`timescale 1ns / 1ps

// First-fit extent allocator. Load requests append a free extent (base, length)
// to a table of FREE_SLOTS entries, kept in load order, and add its length to
// the free total (a full table gives ST_FULL); allocate requests round the byte
// count up to GRAIN_BYTES (a power of two) and take the first extent that is
// large enough, splitting it or, on an exact fit, removing it and moving the
// later entries down. Each request gives exactly one result. A taken request
// waits in the front queue until the back end takes it; the queue holds two
// requests, so the input keeps accepting while the table is busy until the queue
// is full. In the back end, loads, zero-byte and overflow requests and allocates
// on an empty table finish in the idle state; an allocate otherwise scans from
// the first entry, and a miss reads every entry in use. The table RAM has a
// registered read, so each entry takes a read state and then a compare or write
// state. A new request starts only once the previous result has left the output
// register.

module first_fit_extent_allocator #(
  parameter int FREE_SLOTS  = 16,
  parameter int GRAIN_BYTES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  ffea_req_if.sink   in_req,
  ffea_rsp_if.source out_rsp
);
  import ffea_pkg::*;

  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  ffea_front #(
    .GRAIN_BYTES (GRAIN_BYTES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd)
  );

  ffea_back #(
    .FREE_SLOTS (FREE_SLOTS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd),
    .out_rsp (out_rsp)
  );

endmodule
